@@ rtl/hex_text_to_bytes_macros.svh @@
// ---------------------------------------------------------------------------
// hex_text_to_bytes assertion macros
// shared concurrent assertion forms, clocked on clk, disabled in reset
// ---------------------------------------------------------------------------
`ifndef HEX_TEXT_TO_BYTES_MACROS_SVH
`define HEX_TEXT_TO_BYTES_MACROS_SVH

// condition holds at every edge out of reset
`define HTB_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// condition on one edge implies another on the next edge
`define HTB_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

@@ rtl/htb_pkg.sv @@
// ---------------------------------------------------------------------------
// htb_pkg
// shared types and constants of the hex text to bytes parser
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package htb_pkg;

    localparam int unsigned MAX_CHARS    = 65536;
    localparam int unsigned OFFSET_W     = 16;
    localparam logic [OFFSET_W-1:0] OFFSET_LIMIT =
        ((MAX_CHARS - 1) < 65535) ? OFFSET_W'(MAX_CHARS - 1) : 16'hFFFF;
    localparam logic [15:0] COUNT_LIMIT  = 16'hFFFF;

    localparam logic [7:0] CH_BANG    = 8'h21;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_F = 8'h46;
    localparam logic [7:0] CH_UPPER_X = 8'h58;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_F = 8'h66;
    localparam logic [7:0] CH_LOWER_X = 8'h78;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [3:0] NIBBLE_MASK = 4'hF;

    localparam logic [2:0] KIND_OTHER = 3'd0;
    localparam logic [2:0] KIND_DIGIT = 3'd1;
    localparam logic [2:0] KIND_ZERO  = 3'd2;
    localparam logic [2:0] KIND_X     = 3'd3;
    localparam logic [2:0] KIND_BANG  = 3'd4;
    localparam logic [2:0] KIND_BLANK = 3'd5;

    typedef struct packed {
        logic                end_marker;
        logic [2:0]          kind;
        logic [3:0]          digit;
        logic [OFFSET_W-1:0] offset;
    } entry_t;

endpackage

@@ rtl/htb_front.sv @@
// ---------------------------------------------------------------------------
// htb_front
// accepts characters, classifies them and tags each with its offset
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module htb_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           char_valid,
    output logic           char_ready,
    input  logic [7:0]     character,
    input  logic           end_marker,
    output logic           push_valid,
    input  logic           push_ready,
    output htb_pkg::entry_t push_entry
);
    import htb_pkg::*;

    logic [OFFSET_W-1:0] offset_reg;
    logic [OFFSET_W-1:0] offset_next;
    logic                accept;
    logic [2:0]          kind;
    logic [3:0]          digit;

    assign char_ready = push_ready;
    assign push_valid = char_valid;
    assign accept     = char_valid && push_ready;

    always_comb
    begin
        kind  = KIND_OTHER;
        digit = 4'h0;
        if (character == CH_ZERO)
        begin
            kind = KIND_ZERO;
        end
        else if (character > CH_ZERO && character <= CH_NINE)
        begin
            kind  = KIND_DIGIT;
            digit = character[3:0];
        end
        else if (character >= CH_LOWER_A && character <= CH_LOWER_F)
        begin
            kind  = KIND_DIGIT;
            digit = 4'(character - CH_LOWER_A + 8'd10) & NIBBLE_MASK;
        end
        else if (character >= CH_UPPER_A && character <= CH_UPPER_F)
        begin
            kind  = KIND_DIGIT;
            digit = 4'(character - CH_UPPER_A + 8'd10) & NIBBLE_MASK;
        end
        else if (character == CH_LOWER_X || character == CH_UPPER_X)
        begin
            kind = KIND_X;
        end
        else if (character == CH_BANG)
        begin
            kind = KIND_BANG;
        end
        else if (character == CH_SPACE || (character >= CH_TAB && character <= CH_CR))
        begin
            kind = KIND_BLANK;
        end
    end

    assign push_entry.end_marker = end_marker;
    assign push_entry.kind       = kind;
    assign push_entry.digit      = digit;
    assign push_entry.offset     = offset_reg;

    always_comb
    begin
        offset_next = offset_reg;
        if (accept)
        begin
            if (end_marker)
            begin
                offset_next = '0;
            end
            else if (offset_reg < OFFSET_LIMIT)
            begin
                offset_next = offset_reg + OFFSET_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= '0;
        end
        else
        begin
            offset_reg <= offset_next;
        end
    end

endmodule

@@ rtl/htb_queue.sv @@
// ---------------------------------------------------------------------------
// htb_queue
// two-entry queue between the classifier and the packer
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module htb_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    output logic            push_ready,
    input  htb_pkg::entry_t push_entry,
    output logic            pop_valid,
    input  logic            pop_ready,
    output htb_pkg::entry_t pop_entry
);
    import htb_pkg::*;

    `include "hex_text_to_bytes_macros.svh"

    entry_t     entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       push;
    logic       pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_entry  = entry_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `HTB_ASSERT(a_queue_depth, count_reg != 2'd3, "queue count beyond depth")
    `HTB_ASSERT(a_queue_ptrs, (count_reg == 2'd1) == (wr_ptr_reg != rd_ptr_reg), "queue pointers disagree with count")

endmodule

@@ rtl/htb_back.sv @@
// ---------------------------------------------------------------------------
// htb_back
// nibble packer, comment and prefix tracking, result register
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module htb_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            pop_valid,
    output logic            pop_ready,
    input  htb_pkg::entry_t pop_entry,
    output logic            result_valid,
    input  logic            result_ready,
    output logic            has_byte,
    output logic [7:0]      byte_value,
    output logic [15:0]     first_digit_offset,
    output logic            string_done,
    output logic [15:0]     total_bytes,
    output logic            no_hex
);
    import htb_pkg::*;

    `include "hex_text_to_bytes_macros.svh"

    function automatic logic [15:0] sat_inc(input logic [15:0] v);
        sat_inc = (v < COUNT_LIMIT) ? v + 16'd1 : v;
    endfunction

    logic                in_comment_reg,      in_comment_next;
    logic                zero_pending_reg,    zero_pending_next;
    logic [OFFSET_W-1:0] zero_offset_reg,     zero_offset_next;
    logic                low_nibble_next_reg, low_nibble_next_next;
    logic [3:0]          high_nibble_reg,     high_nibble_next;
    logic [OFFSET_W-1:0] byte_start_reg,      byte_start_next;
    logic [15:0]         byte_total_reg,      byte_total_next;

    logic                out_valid_reg, out_valid_next;
    logic                has_byte_reg;
    logic [7:0]          byte_value_reg;
    logic [15:0]         first_offset_reg;
    logic                string_done_reg;
    logic [15:0]         total_bytes_reg;
    logic                no_hex_reg;

    logic                pop;
    logic                got;
    logic                drop;
    logic                produce;
    logic [7:0]          bval;
    logic [OFFSET_W-1:0] boff;
    logic [15:0]         report_total;

    assign pop_ready = !out_valid_reg || result_ready;
    assign pop       = pop_valid && pop_ready;

    always_comb
    begin
        in_comment_next      = in_comment_reg;
        zero_pending_next    = zero_pending_reg;
        zero_offset_next     = zero_offset_reg;
        low_nibble_next_next = low_nibble_next_reg;
        high_nibble_next     = high_nibble_reg;
        byte_start_next      = byte_start_reg;
        byte_total_next      = byte_total_reg;
        got                  = 1'b0;
        drop                 = 1'b0;
        bval                 = 8'h00;
        boff                 = '0;
        report_total         = 16'd0;

        if (pop_entry.end_marker)
        begin
            if (zero_pending_reg)
            begin
                if (!low_nibble_next_next)
                begin
                    high_nibble_next     = 4'h0;
                    byte_start_next      = zero_offset_reg;
                    low_nibble_next_next = 1'b1;
                end
                else
                begin
                    got                  = 1'b1;
                    bval                 = {high_nibble_next, 4'h0};
                    boff                 = byte_start_next;
                    low_nibble_next_next = 1'b0;
                    byte_total_next      = sat_inc(byte_total_next);
                end
            end
            if (low_nibble_next_next)
            begin
                got             = 1'b1;
                bval            = {high_nibble_next, 4'h0};
                boff            = byte_start_next;
                byte_total_next = sat_inc(byte_total_next);
            end
            report_total         = byte_total_next;
            // fresh string
            in_comment_next      = 1'b0;
            zero_pending_next    = 1'b0;
            zero_offset_next     = '0;
            low_nibble_next_next = 1'b0;
            high_nibble_next     = 4'h0;
            byte_start_next      = '0;
            byte_total_next      = 16'd0;
        end
        else
        begin
            if (zero_pending_reg)
            begin
                zero_pending_next = 1'b0;
                if (pop_entry.kind == KIND_X)
                begin
                    drop = 1'b1;
                end
                else if (!low_nibble_next_next)
                begin
                    high_nibble_next     = 4'h0;
                    byte_start_next      = zero_offset_reg;
                    low_nibble_next_next = 1'b1;
                end
                else
                begin
                    got                  = 1'b1;
                    bval                 = {high_nibble_next, 4'h0};
                    boff                 = byte_start_next;
                    low_nibble_next_next = 1'b0;
                    byte_total_next      = sat_inc(byte_total_next);
                end
            end
            if (!drop)
            begin
                if (in_comment_reg)
                begin
                    if (pop_entry.kind == KIND_BLANK)
                    begin
                        in_comment_next = 1'b0;
                    end
                end
                else
                begin
                    case (pop_entry.kind)
                        KIND_BANG:
                        begin
                            in_comment_next = 1'b1;
                        end
                        KIND_ZERO:
                        begin
                            zero_pending_next = 1'b1;
                            zero_offset_next  = pop_entry.offset;
                        end
                        KIND_DIGIT:
                        begin
                            if (!low_nibble_next_next)
                            begin
                                high_nibble_next     = pop_entry.digit;
                                byte_start_next      = pop_entry.offset;
                                low_nibble_next_next = 1'b1;
                            end
                            else
                            begin
                                got                  = 1'b1;
                                bval                 = {high_nibble_next, pop_entry.digit};
                                boff                 = byte_start_next;
                                low_nibble_next_next = 1'b0;
                                byte_total_next      = sat_inc(byte_total_next);
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
        end
    end

    assign produce = pop && (got || pop_entry.end_marker);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (produce)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_comment_reg      <= 1'b0;
            zero_pending_reg    <= 1'b0;
            zero_offset_reg     <= '0;
            low_nibble_next_reg <= 1'b0;
            high_nibble_reg     <= 4'h0;
            byte_start_reg      <= '0;
            byte_total_reg      <= 16'd0;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                in_comment_reg      <= in_comment_next;
                zero_pending_reg    <= zero_pending_next;
                zero_offset_reg     <= zero_offset_next;
                low_nibble_next_reg <= low_nibble_next_next;
                high_nibble_reg     <= high_nibble_next;
                byte_start_reg      <= byte_start_next;
                byte_total_reg      <= byte_total_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (produce)
        begin
            has_byte_reg     <= got;
            byte_value_reg   <= bval;
            first_offset_reg <= 16'(boff);
            string_done_reg  <= pop_entry.end_marker;
            total_bytes_reg  <= report_total;
            no_hex_reg       <= pop_entry.end_marker && (report_total == 16'd0);
        end
    end

    assign result_valid       = out_valid_reg;
    assign has_byte           = has_byte_reg;
    assign byte_value         = byte_value_reg;
    assign first_digit_offset = first_offset_reg;
    assign string_done        = string_done_reg;
    assign total_bytes        = total_bytes_reg;
    assign no_hex             = no_hex_reg;

    `HTB_ASSERT(a_comment_zero, !(in_comment_reg && zero_pending_reg), "held zero inside a comment")
    `HTB_ASSERT_NEXT(a_end_clears, pop && pop_entry.end_marker, !zero_pending_reg && !low_nibble_next_reg && (byte_total_reg == 16'd0), "state not cleared after end of string")
    `HTB_ASSERT_NEXT(a_end_result, pop && pop_entry.end_marker, out_valid_reg && string_done_reg, "end of string gave no report")

endmodule

@@ rtl/hex_text_to_bytes.sv @@
// ---------------------------------------------------------------------------
// hex_text_to_bytes
// packs hex digits of a character stream into bytes with offsets
// ---------------------------------------------------------------------------
// usage
//   char channel: one character beat per char_valid/char_ready handshake;
//   end_marker set on a beat closes the string, character then ignored
//   result channel: a beat per completed byte and one per end marker,
//   the end beat carries string_done, total_bytes, no_hex and any flushed byte
//   throughput: one character per cycle while the receiver takes results, set by the packer update
//   path: a character is held in a queue entry, then its result in the result register
//   characters that give no byte produce no result beat, end beats apart
//   reset: parser and handshake state cleared, offsets restart at zero, nothing pending
//   receiver stall: result register holds, the two-entry queue fills and
//   char_ready drops until the result is taken
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module hex_text_to_bytes (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        char_valid,
    output logic        char_ready,
    input  logic [7:0]  character,
    input  logic        end_marker,
    output logic        result_valid,
    input  logic        result_ready,
    output logic        has_byte,
    output logic [7:0]  byte_value,
    output logic [15:0] first_digit_offset,
    output logic        string_done,
    output logic [15:0] total_bytes,
    output logic        no_hex
);
    import htb_pkg::*;

    logic   push_valid;
    logic   push_ready;
    entry_t push_entry;
    logic   pop_valid;
    logic   pop_ready;
    entry_t pop_entry;

    htb_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .char_ready (char_ready),
        .character  (character),
        .end_marker (end_marker),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry)
    );

    htb_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry)
    );

    htb_back u_back (
        .clk                (clk),
        .rst_n              (rst_n),
        .pop_valid          (pop_valid),
        .pop_ready          (pop_ready),
        .pop_entry          (pop_entry),
        .result_valid       (result_valid),
        .result_ready       (result_ready),
        .has_byte           (has_byte),
        .byte_value         (byte_value),
        .first_digit_offset (first_digit_offset),
        .string_done        (string_done),
        .total_bytes        (total_bytes),
        .no_hex             (no_hex)
    );

endmodule

@@ test/hex_text_to_bytes_checker.sv @@
// ---------------------------------------------------------------------------
// hex_text_to_bytes_checker
// watches both channels of the hex text parser, predicts each result beat
// from the accepted character beats and compares it field by field
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module hex_text_to_bytes_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        char_valid,
    input  logic        char_ready,
    input  logic [7:0]  character,
    input  logic        end_marker,
    input  logic        result_valid,
    input  logic        result_ready,
    input  logic        has_byte,
    input  logic [7:0]  byte_value,
    input  logic [15:0] first_digit_offset,
    input  logic        string_done,
    input  logic [15:0] total_bytes,
    input  logic        no_hex,
    output int          fail_count,
    output int          pending
);
    import htb_pkg::*;

    typedef struct packed {
        logic        has_byte;
        logic [7:0]  byte_value;
        logic [15:0] offset;
        logic        string_done;
        logic [15:0] total;
        logic        no_hex;
    } byte_beat_t;

    byte_beat_t  byte_beat_q[$];

    logic        in_comment;
    logic        zero_held;
    logic [15:0] zero_at;
    logic        low_next;
    logic [3:0]  high_nib;
    logic [15:0] next_offset;
    logic [15:0] byte_start;
    logic [15:0] byte_count;

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic int hex_value(input logic [7:0] c);
        if (c >= CH_ZERO && c <= CH_NINE)
            return int'(c - CH_ZERO);
        if (c >= CH_LOWER_A && c <= CH_LOWER_F)
            return int'(c - CH_LOWER_A) + 10;
        if (c >= CH_UPPER_A && c <= CH_UPPER_F)
            return int'(c - CH_UPPER_A) + 10;
        return -1;
    endfunction

    task automatic clear_parser();
        in_comment  = 1'b0;
        zero_held   = 1'b0;
        zero_at     = '0;
        low_next    = 1'b0;
        high_nib    = '0;
        next_offset = '0;
        byte_start  = '0;
        byte_count  = '0;
    endtask

    task automatic bump_count();
        if (byte_count < COUNT_LIMIT)
            byte_count = byte_count + 16'd1;
    endtask

    task automatic take_nibble(input logic [3:0] val, input logic [15:0] off,
                               output logic done, output logic [7:0] bval,
                               output logic [15:0] boff);
        done = 1'b0;
        bval = '0;
        boff = '0;
        if (!low_next)
        begin
            high_nib   = val;
            byte_start = off;
            low_next   = 1'b1;
        end
        else
        begin
            bval     = {high_nib, val};
            boff     = byte_start;
            low_next = 1'b0;
            bump_count();
            done     = 1'b1;
        end
    endtask

    task automatic parse_beat(input logic [7:0] ch, input logic endm);
        byte_beat_t  e;
        logic        got;
        logic        done;
        logic        skip;
        logic [7:0]  bval;
        logic [15:0] boff;
        logic [7:0]  tv;
        logic [15:0] to;
        logic [15:0] off;
        int          dv;
        e    = '0;
        got  = 1'b0;
        skip = 1'b0;
        bval = '0;
        boff = '0;
        if (endm)
        begin
            if (zero_held)
            begin
                zero_held = 1'b0;
                take_nibble(4'h0, zero_at, done, tv, to);
                if (done)
                begin
                    got  = 1'b1;
                    bval = tv;
                    boff = to;
                end
            end
            // odd final digit goes out as a high nibble
            if (low_next)
            begin
                bval     = {high_nib, 4'h0};
                boff     = byte_start;
                low_next = 1'b0;
                bump_count();
                got      = 1'b1;
            end
            e.has_byte    = got;
            e.byte_value  = got ? bval : 8'h00;
            e.offset      = got ? boff : 16'h0000;
            e.string_done = 1'b1;
            e.total       = byte_count;
            e.no_hex      = (byte_count == 16'h0000);
            byte_beat_q.push_back(e);
            clear_parser();
        end
        else
        begin
            off = next_offset;
            if (next_offset < OFFSET_LIMIT)
                next_offset = next_offset + 16'd1;
            if (zero_held)
            begin
                zero_held = 1'b0;
                if (ch == CH_LOWER_X || ch == CH_UPPER_X)
                    skip = 1'b1;
                else
                begin
                    take_nibble(4'h0, zero_at, done, tv, to);
                    if (done)
                    begin
                        got  = 1'b1;
                        bval = tv;
                        boff = to;
                    end
                end
            end
            if (!skip)
            begin
                if (in_comment)
                begin
                    if (is_blank(ch))
                        in_comment = 1'b0;
                end
                else if (ch == CH_BANG)
                    in_comment = 1'b1;
                else if (ch == CH_ZERO)
                begin
                    zero_held = 1'b1;
                    zero_at   = off;
                end
                else
                begin
                    dv = hex_value(ch);
                    if (dv >= 0)
                    begin
                        take_nibble(dv[3:0], off, done, tv, to);
                        if (done)
                        begin
                            got  = 1'b1;
                            bval = tv;
                            boff = to;
                        end
                    end
                end
            end
            if (got)
            begin
                e.has_byte   = 1'b1;
                e.byte_value = bval;
                e.offset     = boff;
                byte_beat_q.push_back(e);
            end
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        byte_beat_t e;
        if (!rst_n)
        begin
            clear_parser();
            byte_beat_q.delete();
            fail_count = 0;
            pending    = 0;
        end
        else
        begin
            if (char_valid && char_ready)
                parse_beat(character, end_marker);
            if (result_valid && result_ready)
            begin
                if (byte_beat_q.size() == 0)
                    report_mismatch("unexpected result beat", 32'd0, 32'd0);
                else
                begin
                    e = byte_beat_q.pop_front();
                    if (has_byte !== e.has_byte)
                        report_mismatch("has_byte", 32'(has_byte), 32'(e.has_byte));
                    if (byte_value !== e.byte_value)
                        report_mismatch("byte_value", 32'(byte_value), 32'(e.byte_value));
                    if (first_digit_offset !== e.offset)
                        report_mismatch("first_digit_offset", 32'(first_digit_offset),
                                        32'(e.offset));
                    if (string_done !== e.string_done)
                        report_mismatch("string_done", 32'(string_done),
                                        32'(e.string_done));
                    if (total_bytes !== e.total)
                        report_mismatch("total_bytes", 32'(total_bytes), 32'(e.total));
                    if (no_hex !== e.no_hex)
                        report_mismatch("no_hex", 32'(no_hex), 32'(e.no_hex));
                end
            end
            pending = byte_beat_q.size();
        end
    end

endmodule

@@ test/hex_text_to_bytes_tb.sv @@
// ---------------------------------------------------------------------------
// hex_text_to_bytes_tb
// drives character beats into the hex text parser: a directed set of
// strings and random strings under three idling mixes
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module hex_text_to_bytes_tb;

    import htb_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        char_valid;
    logic        char_ready;
    logic [7:0]  character;
    logic        end_marker;
    logic        result_valid;
    logic        result_ready;
    logic        has_byte;
    logic [7:0]  byte_value;
    logic [15:0] first_digit_offset;
    logic        string_done;
    logic [15:0] total_bytes;
    logic        no_hex;

    int          fail_count;
    int          pending;
    int          src_idle;
    int          dst_idle;
    int          beats_sent;

    hex_text_to_bytes u_dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .char_valid         (char_valid),
        .char_ready         (char_ready),
        .character          (character),
        .end_marker         (end_marker),
        .result_valid       (result_valid),
        .result_ready       (result_ready),
        .has_byte           (has_byte),
        .byte_value         (byte_value),
        .first_digit_offset (first_digit_offset),
        .string_done        (string_done),
        .total_bytes        (total_bytes),
        .no_hex             (no_hex)
    );

    hex_text_to_bytes_checker u_chk (
        .clk                (clk),
        .rst_n              (rst_n),
        .char_valid         (char_valid),
        .char_ready         (char_ready),
        .character          (character),
        .end_marker         (end_marker),
        .result_valid       (result_valid),
        .result_ready       (result_ready),
        .has_byte           (has_byte),
        .byte_value         (byte_value),
        .first_digit_offset (first_digit_offset),
        .string_done        (string_done),
        .total_bytes        (total_bytes),
        .no_hex             (no_hex),
        .fail_count         (fail_count),
        .pending            (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_ready <= 1'b0;
        else
            result_ready <= ($urandom_range(99) >= dst_idle);
    end

    function automatic logic [7:0] hex_char();
        int v;
        v = $urandom_range(15);
        if (v < 10)
            return CH_ZERO + 8'(v);
        if ($urandom_range(1))
            return CH_LOWER_A + 8'(v - 10);
        return CH_UPPER_A + 8'(v - 10);
    endfunction

    function automatic logic [7:0] text_char();
        int pick;
        int b;
        pick = $urandom_range(99);
        if (pick < 45)
            return hex_char();
        if (pick < 55)
            return CH_ZERO;
        if (pick < 63)
            return $urandom_range(1) ? CH_LOWER_X : CH_UPPER_X;
        if (pick < 68)
            return CH_BANG;
        if (pick < 78)
        begin
            b = $urandom_range(5);
            return (b == 5) ? CH_SPACE : CH_TAB + 8'(b);
        end
        return 8'($urandom_range(255));
    endfunction

    task automatic send_beat(input logic [7:0] ch, input logic endm);
        while ($urandom_range(99) < src_idle)
        begin
            char_valid <= 1'b0;
            @(posedge clk);
        end
        char_valid <= 1'b1;
        character  <= ch;
        end_marker <= endm;
        do
            @(posedge clk);
        while (!char_ready);
        beats_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_beat(s[i], 1'b0);
    endtask

    // the character on an end beat is ignored, so make it random
    task automatic send_end();
        send_beat(8'($urandom_range(255)), 1'b1);
    endtask

    task automatic random_strings(input int beats);
        int n;
        int stop_at;
        stop_at = beats_sent + beats;
        while (beats_sent < stop_at)
        begin
            n = $urandom_range(24);
            for (int i = 0; i < n; i++)
                send_beat(text_char(), 1'b0);
            send_end();
        end
    endtask

    task automatic drain();
        char_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    initial
    begin
        rst_n      = 1'b0;
        char_valid = 1'b0;
        character  = 8'h00;
        end_marker = 1'b0;
        src_idle   = 0;
        dst_idle   = 0;
        beats_sent = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        src_idle = 30;
        dst_idle = 66;
        // empty string, 0x prefix, comment, held zero, odd flush
        send_end();
        send_text("0x1F");
        send_end();
        send_text("!9 a0");
        send_end();
        send_text("0Xf05g");
        send_beat(8'h00, 1'b0);
        send_beat(8'hFF, 1'b0);
        send_text("E");
        send_end();
        send_text("7");
        send_end();
        random_strings(180);
        drain();

        src_idle = 66;
        dst_idle = 30;
        random_strings(160);

        src_idle = 0;
        dst_idle = 0;
        random_strings(140);

        drain();
        repeat (10) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl
rtl/htb_pkg.sv
rtl/htb_front.sv
rtl/htb_queue.sv
rtl/htb_back.sv
rtl/hex_text_to_bytes.sv
test/hex_text_to_bytes_checker.sv
test/hex_text_to_bytes_tb.sv
